@@ sv/exptok_pkg.sv @@
package exptok_pkg;

  // Token codes carried on the result channel
  typedef enum logic [2:0] {
    TOK_END   = 3'd0,
    TOK_IDENT = 3'd1,
    TOK_NUM   = 3'd2,
    TOK_LE    = 3'd3,
    TOK_GE    = 3'd4,
    TOK_NE    = 3'd5,
    TOK_CHAR  = 3'd6
  } tok_e;

  // Input item kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Character codes the scanner reacts to
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;
  localparam logic [7:0] CH_TILDE = 8'h7e;

  // Hex digit offset for letters a..f
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  // One result queued for the output channel
  typedef struct packed {
    tok_e        token;
    logic [31:0] value;
    logic        last;
  } result_t;

endpackage

@@ sv/expression_tokenizer_core.sv @@
// Expression tokenizer.
// Input channel: one request per character (kind_i = 0, ch_i = ASCII code) or an
// end-of-expression mark (kind_i = 1, or ch_i = 0). A request is taken on a rising
// edge with in_valid_i high and in_stall_o low.
// Output channel: token_o / value_o / last_o, taken on an edge with out_valid_o high
// and out_stall_i low. A request yields zero, one or two tokens; last_o marks the
// final token caused by a request.
// Each request is decoded in the cycle it is taken and its tokens are written into a
// four-entry result queue; the output shows the token at the head of that queue.
// Throughput is one request per cycle while in_stall_o is low; the queue's single read
// port gives one token per cycle while out_stall_i is low and so paces two-token runs.
// in_stall_o rises when fewer than two queue entries are free; it depends only on
// queue fill, so a stalled receiver simply backs up into the input channel.
// Reset empties the queue and returns the scanner to idle with no pending token.
module expression_tokenizer_core #(
  parameter int MAX_IDENT   = 79,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  token_o,
  output logic [31:0] value_o,
  output logic        last_o
);
  import exptok_pkg::*;

  localparam int ILW = $clog2(MAX_IDENT + 1);
  localparam logic [ILW-1:0] IdMax = ILW'(MAX_IDENT);
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_IDENT = 3'd1,
    M_DEC   = 3'd2,
    M_ZERO  = 3'd3,
    M_HEX   = 3'd4,
    M_OP    = 3'd5
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [ILW-1:0]         len_q, len_d;
  logic [7:0]             pend_q, pend_d;

  result_t        queue_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QAW:0]   cnt_q, cnt_d;

  logic accept, pop;
  logic is_end, is_digit, is_alpha, is_space, is_word, is_hex;
  logic [3:0] hex_val;

  // begin-of-token decode
  mode_e                  bg_mode;
  logic [VALUE_WIDTH-1:0] bg_acc;
  logic [ILW-1:0]         bg_len;
  logic [7:0]             bg_pend;
  logic                   bg_emit;

  // flush of the pending token
  logic        fl_v;
  tok_e        fl_tok;
  logic [31:0] fl_val;

  logic        a_v, b_v;
  tok_e        a_tok, b_tok;
  logic [31:0] a_val, b_val;
  result_t     slot0, slot1;
  logic [1:0]  push_n;

  logic [VALUE_WIDTH+31:0] acc_ext;

  assign accept = in_valid_i && !in_stall_o;
  assign pop    = out_valid_o && !out_stall_i;

  // Classify the character
  always_comb begin
    is_end   = (kind_i == KIND_END) || (ch_i == CH_NUL);
    is_digit = (ch_i >= CH_ZERO) && (ch_i <= CH_NINE);
    is_alpha = ((ch_i >= CH_LO_A) && (ch_i <= CH_LO_Z)) ||
               ((ch_i >= CH_UP_A) && (ch_i <= CH_UP_Z));
    is_space = (ch_i == CH_SPACE) || ((ch_i >= CH_TAB) && (ch_i <= CH_CR));
    is_word  = is_alpha || is_digit || (ch_i == CH_UNDER);
    is_hex   = 1'b1;
    hex_val  = '0;
    if (is_digit) begin
      hex_val = 4'(ch_i - CH_ZERO);
    end else if ((ch_i >= CH_LO_A) && (ch_i <= CH_LO_F)) begin
      hex_val = 4'(ch_i - CH_LO_A) + HEX_LETTER_BASE;
    end else if ((ch_i >= CH_UP_A) && (ch_i <= CH_UP_F)) begin
      hex_val = 4'(ch_i - CH_UP_A) + HEX_LETTER_BASE;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Start a new token from the character
  always_comb begin
    bg_mode = M_IDLE;
    bg_acc  = '0;
    bg_len  = '0;
    bg_pend = '0;
    bg_emit = 1'b0;
    if (is_space) begin
      bg_mode = M_IDLE;
    end else if (is_alpha || (ch_i == CH_UNDER)) begin
      bg_mode = M_IDENT;
      bg_len  = ILW'(1);
    end else if (ch_i == CH_ZERO) begin
      bg_mode = M_ZERO;
    end else if (is_digit) begin
      bg_mode = M_DEC;
      bg_acc  = VALUE_WIDTH'(hex_val);
    end else if ((ch_i == CH_LT) || (ch_i == CH_GT) || (ch_i == CH_TILDE)) begin
      bg_mode = M_OP;
      bg_pend = ch_i;
    end else begin
      bg_emit = 1'b1;
    end
  end

  // Token held by the current state
  assign acc_ext = {32'b0, acc_q};
  always_comb begin
    fl_v   = 1'b1;
    fl_tok = TOK_CHAR;
    fl_val = '0;
    unique case (mode_q)
      M_IDENT: begin
        fl_tok = TOK_IDENT;
        fl_val = 32'(len_q);
      end
      M_DEC, M_HEX: begin
        fl_tok = TOK_NUM;
        fl_val = acc_ext[31:0];
      end
      M_ZERO: begin
        fl_tok = TOK_NUM;
      end
      M_OP: begin
        fl_tok = TOK_CHAR;
        fl_val = 32'(pend_q);
      end
      default: fl_v = 1'b0;
    endcase
  end

  // Next state and up to two tokens
  always_comb begin
    logic cont;
    cont   = 1'b0;
    mode_d = mode_q;
    acc_d  = acc_q;
    len_d  = len_q;
    pend_d = pend_q;
    a_v    = 1'b0;
    a_tok  = fl_tok;
    a_val  = fl_val;
    b_v    = 1'b0;
    b_tok  = TOK_CHAR;
    b_val  = 32'(ch_i);
    if (is_end) begin
      a_v    = fl_v;
      b_v    = 1'b1;
      b_tok  = TOK_END;
      b_val  = '0;
      mode_d = M_IDLE;
      acc_d  = '0;
      len_d  = '0;
      pend_d = '0;
    end else if ((mode_q == M_OP) && (ch_i == CH_EQ)) begin
      // Join the pending operator with '='
      b_v    = 1'b1;
      b_val  = 32'(pend_q);
      b_tok  = (pend_q == CH_LT) ? TOK_LE : (pend_q == CH_GT) ? TOK_GE : TOK_NE;
      mode_d = M_IDLE;
      acc_d  = '0;
      len_d  = '0;
      pend_d = '0;
    end else begin
      unique case (mode_q)
        M_IDENT: begin
          cont = is_word;
          if (is_word && (len_q < IdMax)) len_d = len_q + ILW'(1);
        end
        M_DEC: begin
          cont  = is_digit;
          acc_d = (acc_q << 3) + (acc_q << 1) + VALUE_WIDTH'(hex_val);
        end
        M_ZERO: begin
          cont = is_digit || (ch_i == CH_LO_X);
          if (ch_i == CH_LO_X) begin
            mode_d = M_HEX;
            acc_d  = '0;
          end else begin
            mode_d = M_DEC;
            acc_d  = VALUE_WIDTH'(hex_val);
          end
        end
        M_HEX: begin
          cont  = is_hex;
          acc_d = (acc_q << 4) + VALUE_WIDTH'(hex_val);
        end
        default: cont = 1'b0;
      endcase
      if (!cont) begin
        // Close the pending token, then treat the character as a fresh start
        a_v    = fl_v;
        b_v    = bg_emit;
        mode_d = bg_mode;
        acc_d  = bg_acc;
        len_d  = bg_len;
        pend_d = bg_pend;
      end
    end
  end

  // Pack the tokens into consecutive queue slots
  always_comb begin
    slot0.token = a_v ? a_tok : b_tok;
    slot0.value = a_v ? a_val : b_val;
    slot0.last  = !(a_v && b_v);
    slot1.token = b_tok;
    slot1.value = b_val;
    slot1.last  = 1'b1;
    push_n      = accept ? (2'(a_v) + 2'(b_v)) : 2'd0;
    cnt_d       = cnt_q + (QAW+1)'(push_n) - (QAW+1)'(pop);
  end

  assign in_stall_o  = cnt_q > (QAW+1)'(QDEPTH - 2);
  assign out_valid_o = cnt_q != '0;
  assign token_o     = queue_q[rd_q].token;
  assign value_o     = queue_q[rd_q].value;
  assign last_o      = queue_q[rd_q].last;

  // Hold scanner state and queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      acc_q  <= '0;
      len_q  <= '0;
      pend_q <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
        len_q  <= len_d;
        pend_q <= pend_d;
      end
      wr_q  <= wr_q + QAW'(push_n);
      if (pop) rd_q <= rd_q + QAW'(1);
      cnt_q <= cnt_d;
    end
  end

  // Write queue entries
  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) queue_q[wr_q] <= slot0;
    if (push_n == 2'd2) queue_q[wr_q + QAW'(1)] <= slot1;
  end

endmodule
